FILE: hdl/pgm_pkg.sv
// Package for the binary graymap stream parser: parse phases, result kinds,
// character codes and the dimension width. No dependencies.
package pgm_pkg;

	localparam int DIM_BITS = 16;
	localparam int ACC_BITS = DIM_BITS + 4;

	localparam logic [DIM_BITS-1:0] DIM_LIMIT      = '1;
	localparam logic [DIM_BITS-1:0] DIM_SAT_THRESH = DIM_BITS'(((1 << DIM_BITS) - 1) / 10);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [3:0] {
		PH_MAGIC0 = 4'd0,
		PH_MAGIC1 = 4'd1,
		PH_WS_W   = 4'd2,
		PH_NUM_W  = 4'd3,
		PH_WS_H   = 4'd4,
		PH_NUM_H  = 4'd5,
		PH_WS_M   = 4'd6,
		PH_NUM_M  = 4'd7,
		PH_PIXELS = 4'd8,
		PH_DONE   = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER   = 2'd0,
		KIND_PIXEL    = 2'd1,
		KIND_TRUNCATE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  pixel_value;
		logic [15:0] column;
		logic [15:0] row;
		logic        last_pixel;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] max_gray;
	} result_t;

endpackage

FILE: hdl/pgm_in_if.sv
// Byte input channel of the graymap parser: valid/ready with one file byte
// and its end-of-file mark. No dependencies.
interface pgm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_end;

	modport source (output valid, output data_byte, output file_end, input ready);
	modport sink (input valid, input data_byte, input file_end, output ready);
endinterface

FILE: hdl/pgm_out_if.sv
// Result channel of the graymap parser: valid/ready with header, pixel or
// truncation fields. No dependencies.
interface pgm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  pixel_value;
	logic [15:0] column;
	logic [15:0] row;
	logic        last_pixel;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [15:0] max_gray;

	modport source (output valid, output kind, output pixel_value, output column,
		output row, output last_pixel, output image_width, output image_height,
		output max_gray, input ready);
	modport sink (input valid, input kind, input pixel_value, input column,
		input row, input last_pixel, input image_width, input image_height,
		input max_gray, output ready);
endinterface

FILE: hdl/pgm_binary_stream_parser.sv
// Binary graymap (P5) stream parser: header numbers, then one result per pixel.
// Depends on pgm_pkg, pgm_in_if and pgm_out_if.
// A result is registered and presented in the cycle after the byte that causes it.
// Throughput: one byte per cycle; a waiting result holds the input, so a byte is
// taken whenever the result slot is empty or drains in the same cycle.
// Reset: parse phase, counters, numbers and result valid clear at once.
module pgm_binary_stream_parser
	import pgm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pgm_in_if.sink      byte_in,
	pgm_out_if.source   result_out
);

	phase_t              phase_q, phase_d;
	logic [DIM_BITS-1:0] acc_q, acc_d;
	logic                frozen_q, frozen_d;
	logic [DIM_BITS-1:0] width_q, width_d;
	logic [DIM_BITS-1:0] height_q, height_d;
	logic [DIM_BITS-1:0] maxg_q, maxg_d;
	logic [DIM_BITS-1:0] col_q, col_d;
	logic [DIM_BITS-1:0] row_q, row_d;

	logic    out_valid_q;
	result_t res_q, res_d;
	logic    emit;

	logic                in_fire;
	logic [7:0]          b;
	logic                is_ws, is_dig;
	logic [ACC_BITS-1:0] acc_sum;
	logic [DIM_BITS-1:0] acc_next;
	logic                last_col, last_pix;

	assign in_fire        = byte_in.valid && byte_in.ready;
	assign byte_in.ready  = !out_valid_q || result_out.ready;
	assign b              = byte_in.data_byte;
	assign is_ws          = (b == CH_CR) || (b == CH_TAB) || (b == CH_LF) || (b == CH_SPACE);
	assign is_dig         = (b >= CH_ZERO) && (b <= CH_NINE);

	assign acc_sum  = ({4'b0, acc_q} * ACC_BITS'(10)) + ACC_BITS'(b[3:0]);
	assign acc_next = ((acc_q > DIM_SAT_THRESH) || (acc_sum > {4'b0, DIM_LIMIT}))
		? DIM_LIMIT : acc_sum[DIM_BITS-1:0];

	assign last_col = ({1'b0, col_q} + (DIM_BITS+1)'(1)) >= {1'b0, width_q};
	assign last_pix = last_col && (({1'b0, row_q} + (DIM_BITS+1)'(1)) >= {1'b0, height_q});

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		frozen_d = frozen_q;
		width_d  = width_q;
		height_d = height_q;
		maxg_d   = maxg_q;
		col_d    = col_q;
		row_d    = row_q;
		emit     = 1'b0;
		res_d    = '0;

		case (phase_q)
			PH_MAGIC0: phase_d = PH_MAGIC1;
			PH_MAGIC1: phase_d = PH_WS_W;
			PH_WS_W, PH_WS_H, PH_WS_M: begin
				if (!is_ws) begin
					if (!frozen_q && is_dig) acc_d = acc_next;
					else frozen_d = 1'b1;
					case (phase_q)
						PH_WS_W: phase_d = PH_NUM_W;
						PH_WS_H: phase_d = PH_NUM_H;
						default: phase_d = PH_NUM_M;
					endcase
				end
			end
			PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
				if (is_ws) begin
					acc_d    = '0;
					frozen_d = 1'b0;
					case (phase_q)
						PH_NUM_W: begin
							width_d = acc_q;
							phase_d = PH_WS_H;
						end
						PH_NUM_H: begin
							height_d = acc_q;
							phase_d  = PH_WS_M;
						end
						default: begin
							maxg_d  = acc_q;
							phase_d = (width_q != '0 && height_q != '0) ? PH_PIXELS : PH_DONE;
							col_d   = '0;
							row_d   = '0;
							emit    = 1'b1;
							res_d.kind = KIND_HEADER;
						end
					endcase
				end else if (!frozen_q && is_dig) begin
					acc_d = acc_next;
				end else begin
					frozen_d = 1'b1;
				end
			end
			PH_PIXELS: begin
				emit              = 1'b1;
				res_d.kind        = KIND_PIXEL;
				res_d.pixel_value = b;
				res_d.column      = 16'(col_q);
				res_d.row         = 16'(row_q);
				res_d.last_pixel  = last_pix;
				if (last_pix) begin
					phase_d = PH_DONE;
				end else if (last_col) begin
					col_d = '0;
					row_d = row_q + DIM_BITS'(1);
				end else begin
					col_d = col_q + DIM_BITS'(1);
				end
			end
			default: phase_d = PH_DONE;
		endcase

		res_d.image_width  = 16'(width_d);
		res_d.image_height = 16'(height_d);
		res_d.max_gray     = 16'(maxg_d);

		if (byte_in.file_end) begin
			if (phase_d != PH_DONE) begin
				emit             = 1'b1;
				res_d.kind       = KIND_TRUNCATE;
				res_d.last_pixel = 1'b0;
			end
			phase_d  = PH_MAGIC0;
			acc_d    = '0;
			frozen_d = 1'b0;
			width_d  = '0;
			height_d = '0;
			maxg_d   = '0;
			col_d    = '0;
			row_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC0;
			acc_q       <= '0;
			frozen_q    <= 1'b0;
			width_q     <= '0;
			height_q    <= '0;
			maxg_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			acc_q       <= acc_d;
			frozen_q    <= frozen_d;
			width_q     <= width_d;
			height_q    <= height_d;
			maxg_q      <= maxg_d;
			col_q       <= col_d;
			row_q       <= row_d;
			out_valid_q <= emit;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			res_q <= res_d;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.kind         = res_q.kind;
	assign result_out.pixel_value  = res_q.pixel_value;
	assign result_out.column       = res_q.column;
	assign result_out.row          = res_q.row;
	assign result_out.last_pixel   = res_q.last_pixel;
	assign result_out.image_width  = res_q.image_width;
	assign result_out.image_height = res_q.image_height;
	assign result_out.max_gray     = res_q.max_gray;

	// final pixel sits at the bottom-right corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.kind == KIND_PIXEL && res_q.last_pixel)
		|-> (res_q.column == res_q.image_width - 16'd1
			&& res_q.row == res_q.image_height - 16'd1))
		else $error("last pixel not at image corner");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && byte_in.file_end) |=> (phase_q == PH_MAGIC0 && width_q == '0))
		else $error("parser did not restart after file end");

	a_pixels_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (width_q != '0 && height_q != '0 && col_q < width_q))
		else $error("pixel phase with empty image or column overrun");

endmodule
